@@ hw/rtl/dst_pkg.sv @@
// shared types and constants for the device slot table
package dst_pkg;
    localparam int DEVICE_SLOTS = 16;
    localparam int IDX_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam logic [15:0] INVALID_SHORT = 16'hFFFF;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_LEAVING = 2'd2;

    localparam logic [2:0] CMD_UPSERT    = 3'd0;
    localparam logic [2:0] CMD_FIND_SH   = 3'd1;
    localparam logic [2:0] CMD_FIND_IEEE = 3'd2;
    localparam logic [2:0] CMD_RESOLVE   = 3'd3;
    localparam logic [2:0] CMD_CLAIM     = 3'd4;
    localparam logic [2:0] CMD_RELEASE   = 3'd5;
    localparam logic [2:0] CMD_RESET     = 3'd6;
    localparam logic [2:0] CMD_RECLAIM   = 3'd7;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN1 = 8'b00000010,
        S_ALLOC = 8'b00000100,
        S_AEND  = 8'b00001000,
        S_SCAN2 = 8'b00010000,
        S_EVICT = 8'b00100000,
        S_APPLY = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the command
        logic scan_clr;   // clear scan pointer and eviction search result
        logic scan1;      // primary search step
        logic alloc;      // search empty slot step
        logic scan2;      // eviction search step
        logic evict;      // evict the found holder
        logic apply;      // execute the command on the selected slot
        logic emit;       // drive the result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       scan_last;
        logic       found;
        logic       found2;
    } t_sts;
endpackage

@@ hw/rtl/dst_ctrl.sv @@
// controller state machine of the device slot table
module dst_ctrl import dst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_sts.cmd inside {CMD_UPSERT, CMD_FIND_SH, CMD_FIND_IEEE}) begin
                    o_ctl.scan1 = 1'b1;
                    if (i_sts.scan_last) begin
                        if (i_sts.cmd == CMD_UPSERT) begin
                            o_ctl.scan_clr = 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_ALLOC: begin
                if (i_sts.found) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_SCAN2;
                end else begin
                    o_ctl.alloc = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_AEND;
                    end
                end
            end
            S_AEND: begin
                if (i_sts.found) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_SCAN2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN2: begin
                o_ctl.scan2 = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_ctl.evict = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_ctl.apply = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_ctl.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/dst_datapath.sv @@
// slot storage, scan pointer and command execution of the device slot table
module dst_datapath import dst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_nwk_addr,
    input  logic [63:0] i_ieee_addr,
    input  logic        i_ieee_present,
    input  logic        i_include_inactive,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_generation_tag,
    input  logic        i_outstanding_work,
    output logic        o_valid,
    output logic        o_hit,
    output logic [3:0]  o_hit_index,
    output logic [31:0] o_hit_generation,
    output logic [15:0] o_hit_nwk_addr,
    output logic [15:0] o_hit_previous_short,
    output logic [1:0]  o_hit_state,
    output logic        o_hit_ieee_known,
    output logic [63:0] o_hit_ieee,
    output logic        o_discovery_granted
);
    logic [1:0]  r_status [DEVICE_SLOTS];
    logic [31:0] r_gen    [DEVICE_SLOTS];
    logic [15:0] r_short  [DEVICE_SLOTS];
    logic [15:0] r_prev   [DEVICE_SLOTS];
    logic [15:0] r_disc   [DEVICE_SLOTS];
    logic [63:0] r_ieee   [DEVICE_SLOTS];
    logic        r_known  [DEVICE_SLOTS];
    logic        r_out    [DEVICE_SLOTS];

    logic [2:0]  r_cmd;
    logic [15:0] r_a;
    logic [63:0] r_ie;
    logic        r_has, r_any, r_work;
    logic [3:0]  r_idx_in;
    logic [31:0] r_gtag;

    logic [IDX_W-1:0] r_ptr;
    logic             r_found, r_found2, r_granted, r_valid;
    logic [IDX_W-1:0] r_sel, r_old;

    logic [IDX_W-1:0] w_idx;
    logic             w_in_range, w_usable, w_m1, w_m2;
    logic [1:0]       w_st;

    assign w_in_range = ({28'd0, r_idx_in} < 32'(DEVICE_SLOTS));
    assign w_idx = IDX_W'({28'd0, r_idx_in});
    assign w_st = r_status[r_ptr];
    assign w_usable = (w_st != ST_EMPTY) && (r_any || w_st == ST_ACTIVE);
    always_comb begin
        w_m1 = 1'b0;
        case (r_cmd)
            CMD_UPSERT:
                w_m1 = r_has ? ((w_st != ST_EMPTY) && r_known[r_ptr] && r_ieee[r_ptr] == r_ie)
                             : ((w_st == ST_ACTIVE) && r_short[r_ptr] == r_a);
            CMD_FIND_SH: w_m1 = w_usable && r_short[r_ptr] == r_a;
            CMD_FIND_IEEE: w_m1 = w_usable && r_known[r_ptr] && r_ieee[r_ptr] == r_ie;
            default: w_m1 = 1'b0;
        endcase
    end
    assign w_m2 = (w_st != ST_EMPTY) && (r_short[r_ptr] == r_a);

    assign o_sts.cmd = r_cmd;
    assign o_sts.scan_last = (32'(r_ptr) == DEVICE_SLOTS - 1);
    assign o_sts.found = r_found;
    assign o_sts.found2 = r_found2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_found2 <= 1'b0;
            r_granted <= 1'b0;
            r_ptr <= '0;
            for (int i = 0; i < DEVICE_SLOTS; i++) begin
                r_status[i] <= ST_EMPTY;
                r_gen[i] <= '0;
                r_short[i] <= '0;
                r_prev[i] <= '0;
                r_disc[i] <= '0;
                r_ieee[i] <= '0;
                r_known[i] <= 1'b0;
                r_out[i] <= 1'b0;
            end
        end else begin
            r_valid <= i_ctl.emit;
            if (i_ctl.load) begin
                r_cmd <= i_command;
                r_a <= i_nwk_addr;
                r_ie <= i_ieee_addr;
                r_has <= i_ieee_present;
                r_any <= i_include_inactive;
                r_idx_in <= i_slot_index;
                r_gtag <= i_generation_tag;
                r_work <= i_outstanding_work;
                r_found <= 1'b0;
                r_granted <= 1'b0;
            end
            if (i_ctl.scan_clr) begin
                r_ptr <= '0;
                r_found2 <= 1'b0;
            end else if (i_ctl.scan1 || i_ctl.alloc || i_ctl.scan2) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_ctl.scan1 && !r_found && w_m1) begin
                r_found <= 1'b1;
                r_sel <= r_ptr;
            end
            if (i_ctl.alloc && w_st == ST_EMPTY) begin
                r_found <= 1'b1;
                r_sel <= r_ptr;
                r_gen[r_ptr] <= (r_gen[r_ptr] == 32'hFFFF_FFFF) ? 32'd1 : r_gen[r_ptr] + 32'd1;
                r_status[r_ptr] <= ST_ACTIVE;
                r_short[r_ptr] <= r_a;
                r_prev[r_ptr] <= INVALID_SHORT;
                r_disc[r_ptr] <= INVALID_SHORT;
                r_ieee[r_ptr] <= '0;
                r_known[r_ptr] <= 1'b0;
                r_out[r_ptr] <= 1'b0;
            end
            if (i_ctl.scan2 && !r_found2 && w_m2) begin
                r_found2 <= 1'b1;
                r_old <= r_ptr;
            end
            if (i_ctl.evict && r_found2 && r_old != r_sel) begin
                if (r_out[r_old]) begin
                    r_short[r_old] <= INVALID_SHORT;
                    r_status[r_old] <= ST_LEAVING;
                end else begin
                    r_short[r_old] <= INVALID_SHORT;
                    r_status[r_old] <= ST_EMPTY;
                    r_ieee[r_old] <= '0;
                    r_known[r_old] <= 1'b0;
                end
            end
            if (i_ctl.apply) begin
                case (r_cmd)
                    CMD_UPSERT: begin
                        r_status[r_sel] <= ST_ACTIVE;
                        if (r_short[r_sel] != INVALID_SHORT && r_short[r_sel] != r_a)
                            r_prev[r_sel] <= r_short[r_sel];
                        r_short[r_sel] <= r_a;
                        if (r_has) begin
                            r_ieee[r_sel] <= r_ie;
                            r_known[r_sel] <= 1'b1;
                        end
                    end
                    CMD_RESOLVE: begin
                        r_sel <= w_idx;
                        r_found <= w_in_range && (r_status[w_idx] != ST_EMPTY)
                                   && (r_any || r_status[w_idx] == ST_ACTIVE)
                                   && r_gen[w_idx] == r_gtag;
                    end
                    default: begin
                        r_sel <= w_idx;
                        r_found <= w_in_range;
                        if (w_in_range) begin
                            case (r_cmd)
                                CMD_CLAIM: begin
                                    if (r_status[w_idx] == ST_ACTIVE
                                        && r_short[w_idx] != INVALID_SHORT
                                        && r_disc[w_idx] != r_short[w_idx]) begin
                                        r_disc[w_idx] <= r_short[w_idx];
                                        r_granted <= 1'b1;
                                    end
                                end
                                CMD_RELEASE: begin
                                    if (r_disc[w_idx] == r_a) r_disc[w_idx] <= INVALID_SHORT;
                                end
                                CMD_RESET: r_disc[w_idx] <= INVALID_SHORT;
                                default: begin
                                    r_out[w_idx] <= r_work;
                                    if (r_status[w_idx] == ST_LEAVING && !r_work) begin
                                        r_short[w_idx] <= INVALID_SHORT;
                                        r_ieee[w_idx] <= '0;
                                        r_known[w_idx] <= 1'b0;
                                        r_status[w_idx] <= ST_EMPTY;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_valid = r_valid;
        o_hit = r_valid && r_found;
        o_hit_index = '0;
        o_hit_generation = '0;
        o_hit_nwk_addr = '0;
        o_hit_previous_short = '0;
        o_hit_state = '0;
        o_hit_ieee_known = 1'b0;
        o_hit_ieee = '0;
        o_discovery_granted = 1'b0;
        if (o_hit) begin
            o_hit_index = 4'(32'(r_sel));
            o_hit_generation = r_gen[r_sel];
            o_hit_nwk_addr = r_short[r_sel];
            o_hit_previous_short = r_prev[r_sel];
            o_hit_state = r_status[r_sel];
            o_hit_ieee_known = r_known[r_sel];
            o_hit_ieee = r_ieee[r_sel];
            o_discovery_granted = r_granted;
        end
    end
endmodule

@@ hw/rtl/device_slot_table.sv @@
// top level of the device slot table
// lookups scan every slot; upsert adds an empty-slot search and an eviction scan; slot commands skip the scans
// a new command is taken only after the strobe; busy stays high through the strobe
// the sixteen-slot scans of the controller set the upsert and lookup latency
// synchronous active-low reset empties every slot and clears all slot fields
// the result is shown for one cycle on o_done; the receiver cannot stall
module device_slot_table import dst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_nwk_addr,
    input  logic [63:0] i_ieee_addr,
    input  logic        i_ieee_present,
    input  logic        i_include_inactive,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_generation_tag,
    input  logic        i_outstanding_work,
    output logic        o_done,
    output logic        o_hit,
    output logic [3:0]  o_hit_index,
    output logic [31:0] o_hit_generation,
    output logic [15:0] o_hit_nwk_addr,
    output logic [15:0] o_hit_previous_short,
    output logic [1:0]  o_hit_state,
    output logic        o_hit_ieee_known,
    output logic [63:0] o_hit_ieee,
    output logic        o_discovery_granted
);
    t_ctl w_ctl;
    t_sts w_sts;
    logic w_busy;

    assign busy = w_busy || o_done;

    dst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start && !o_done),
        .busy(w_busy), .i_sts(w_sts), .o_ctl(w_ctl)
    );

    dst_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .o_sts(w_sts),
        .i_command(i_command), .i_nwk_addr(i_nwk_addr), .i_ieee_addr(i_ieee_addr),
        .i_ieee_present(i_ieee_present), .i_include_inactive(i_include_inactive),
        .i_slot_index(i_slot_index), .i_generation_tag(i_generation_tag),
        .i_outstanding_work(i_outstanding_work), .o_valid(o_done), .o_hit(o_hit),
        .o_hit_index(o_hit_index), .o_hit_generation(o_hit_generation),
        .o_hit_nwk_addr(o_hit_nwk_addr), .o_hit_previous_short(o_hit_previous_short),
        .o_hit_state(o_hit_state), .o_hit_ieee_known(o_hit_ieee_known),
        .o_hit_ieee(o_hit_ieee), .o_discovery_granted(o_discovery_granted)
    );
endmodule

@@ hw/rtl/dst_checker.sv @@
// port-level assertions for the device slot table
module dst_checker import dst_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_hit,
    input logic [1:0] o_hit_state,
    input logic       o_discovery_granted
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result outside a transaction");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit || o_discovery_granted) |-> o_done) else $error("hit without strobe");
    a_grant_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_discovery_granted |-> (o_hit && o_hit_state == ST_ACTIVE))
        else $error("grant on inactive slot");
endmodule

bind device_slot_table dst_checker u_dst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_hit(o_hit), .o_hit_state(o_hit_state), .o_discovery_granted(o_discovery_granted)
);

@@ dv/device_slot_table_chk.sv @@
// checker for the device slot table: predicts each transaction and compares results
`timescale 1ns / 100ps
module device_slot_table_chk import dst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_nwk_addr,
    input  logic [63:0] i_ieee_addr,
    input  logic        i_ieee_present,
    input  logic        i_include_inactive,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_generation_tag,
    input  logic        i_outstanding_work,
    input  logic        o_done,
    input  logic        o_hit,
    input  logic [3:0]  o_hit_index,
    input  logic [31:0] o_hit_generation,
    input  logic [15:0] o_hit_nwk_addr,
    input  logic [15:0] o_hit_previous_short,
    input  logic [1:0]  o_hit_state,
    input  logic        o_hit_ieee_known,
    input  logic [63:0] o_hit_ieee,
    input  logic        o_discovery_granted,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic        hit;
        logic [3:0]  index;
        logic [31:0] generation;
        logic [15:0] nwk_addr;
        logic [15:0] prev_short;
        logic [1:0]  state;
        logic        ieee_known;
        logic [63:0] ieee;
        logic        granted;
    } t_answer;

    logic [1:0]  status [DEVICE_SLOTS];
    logic [31:0] gen_tag [DEVICE_SLOTS];
    logic [15:0] cur_short [DEVICE_SLOTS];
    logic [15:0] prev_short [DEVICE_SLOTS];
    logic [15:0] disc_short [DEVICE_SLOTS];
    logic [63:0] hw_addr [DEVICE_SLOTS];
    logic        hw_known [DEVICE_SLOTS];
    logic        work_flag [DEVICE_SLOTS];
    t_answer     answers [$];

    function automatic logic bool_usable(int i, logic any);
        return status[i] != ST_EMPTY && (any || status[i] == ST_ACTIVE);
    endfunction

    function automatic int find_short(logic [15:0] a, logic any);
        for (int i = 0; i < DEVICE_SLOTS; i++)
            if (bool_usable(i, any) && cur_short[i] == a) return i;
        return -1;
    endfunction

    function automatic int find_hw(logic [63:0] a, logic any);
        for (int i = 0; i < DEVICE_SLOTS; i++)
            if (bool_usable(i, any) && hw_known[i] && hw_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic void reclaim_slot(int i);
        if (status[i] == ST_LEAVING && !work_flag[i]) begin
            cur_short[i] = INVALID_SHORT;
            hw_addr[i] = '0;
            hw_known[i] = 1'b0;
            status[i] = ST_EMPTY;
        end
    endfunction

    function automatic int upsert_slot(logic [15:0] a, logic has_hw, logic [63:0] hw);
        int s;
        int old;
        s = has_hw ? find_hw(hw, 1'b1) : find_short(a, 1'b0);
        if (s < 0) begin
            for (int i = 0; i < DEVICE_SLOTS; i++)
                if (s < 0 && status[i] == ST_EMPTY) begin
                    gen_tag[i] = (gen_tag[i] == 32'hFFFF_FFFF) ? 32'd1 : gen_tag[i] + 32'd1;
                    status[i] = ST_ACTIVE;
                    cur_short[i] = a;
                    prev_short[i] = INVALID_SHORT;
                    disc_short[i] = INVALID_SHORT;
                    hw_addr[i] = '0;
                    hw_known[i] = 1'b0;
                    work_flag[i] = 1'b0;
                    s = i;
                end
        end
        if (s < 0) return -1;
        old = find_short(a, 1'b1);
        if (old >= 0 && old != s) begin
            cur_short[old] = INVALID_SHORT;
            status[old] = ST_LEAVING;
            reclaim_slot(old);
        end
        status[s] = ST_ACTIVE;
        if (cur_short[s] != INVALID_SHORT && cur_short[s] != a) prev_short[s] = cur_short[s];
        cur_short[s] = a;
        if (has_hw) begin
            hw_addr[s] = hw;
            hw_known[s] = 1'b1;
        end
        return s;
    endfunction

    function automatic t_answer apply_command();
        t_answer r;
        int s;
        int idx;
        logic granted;
        s = -1;
        idx = i_slot_index;
        granted = 1'b0;
        r = '0;
        case (i_command)
            CMD_UPSERT:    s = upsert_slot(i_nwk_addr, i_ieee_present, i_ieee_addr);
            CMD_FIND_SH:   s = find_short(i_nwk_addr, i_include_inactive);
            CMD_FIND_IEEE: s = find_hw(i_ieee_addr, i_include_inactive);
            CMD_RESOLVE:
                if (idx < DEVICE_SLOTS && bool_usable(idx, i_include_inactive)
                        && gen_tag[idx] == i_generation_tag) s = idx;
            default:
                if (idx < DEVICE_SLOTS) begin
                    s = idx;
                    if (i_command == CMD_CLAIM) begin
                        if (status[s] == ST_ACTIVE && cur_short[s] != INVALID_SHORT
                                && disc_short[s] != cur_short[s]) begin
                            disc_short[s] = cur_short[s];
                            granted = 1'b1;
                        end
                    end else if (i_command == CMD_RELEASE) begin
                        if (disc_short[s] == i_nwk_addr) disc_short[s] = INVALID_SHORT;
                    end else if (i_command == CMD_RESET) begin
                        disc_short[s] = INVALID_SHORT;
                    end else begin
                        work_flag[s] = i_outstanding_work;
                        reclaim_slot(s);
                    end
                end
        endcase
        if (s >= 0) begin
            r.hit = 1'b1;
            r.index = s[3:0];
            r.generation = gen_tag[s];
            r.nwk_addr = cur_short[s];
            r.prev_short = prev_short[s];
            r.state = status[s];
            r.ieee_known = hw_known[s];
            r.ieee = hw_addr[s];
            r.granted = granted;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEVICE_SLOTS; i++) begin
                status[i] = ST_EMPTY;
                gen_tag[i] = '0;
                cur_short[i] = '0;
                prev_short[i] = '0;
                disc_short[i] = '0;
                hw_addr[i] = '0;
                hw_known[i] = 1'b0;
                work_flag[i] = 1'b0;
            end
            answers.delete();
            fail_count = 0;
        end else begin
            if (o_done) begin
                got = {o_hit, o_hit_index, o_hit_generation, o_hit_nwk_addr,
                       o_hit_previous_short, o_hit_state, o_hit_ieee_known, o_hit_ieee,
                       o_discovery_granted};
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    want = answers.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) answers.push_back(apply_command());
        end
        pending = answers.size();
    end
endmodule

@@ dv/device_slot_table_tb.sv @@
// testbench top for the device slot table: stimulus, timeout and verdict
`timescale 1ns / 100ps
module device_slot_table_tb;
    import dst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = CMD_UPSERT;
    logic [15:0] i_nwk_addr = '0;
    logic [63:0] i_ieee_addr = '0;
    logic        i_ieee_present = 1'b0;
    logic        i_include_inactive = 1'b0;
    logic [3:0]  i_slot_index = '0;
    logic [31:0] i_generation_tag = '0;
    logic        i_outstanding_work = 1'b0;
    logic        o_done;
    logic        o_hit;
    logic [3:0]  o_hit_index;
    logic [31:0] o_hit_generation;
    logic [15:0] o_hit_nwk_addr;
    logic [15:0] o_hit_previous_short;
    logic [1:0]  o_hit_state;
    logic        o_hit_ieee_known;
    logic [63:0] o_hit_ieee;
    logic        o_discovery_granted;
    int          fail_count;
    int          pending;

    logic [15:0] short_pool [8];
    logic [63:0] hw_pool [6];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    device_slot_table uut (.*);
    device_slot_table_chk chk (.*);

    task automatic issue(logic [2:0] cmd, logic [15:0] sa, logic [63:0] hw, logic hp,
                         logic inc, logic [3:0] idx, logic [31:0] gen, logic wk);
        i_command <= cmd;
        i_nwk_addr <= sa;
        i_ieee_addr <= hw;
        i_ieee_present <= hp;
        i_include_inactive <= inc;
        i_slot_index <= idx;
        i_generation_tag <= gen;
        i_outstanding_work <= wk;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [2:0] cmd;
        logic [15:0] sa;
        logic [63:0] hw;
        logic [31:0] gen;
        cmd = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) cmd = CMD_UPSERT;
        sa = ($urandom_range(0, 9) == 0) ? 16'($urandom) : short_pool[$urandom_range(0, 7)];
        hw = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : hw_pool[$urandom_range(0, 5)];
        gen = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 12);
        issue(cmd, sa, hw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)), gen, $urandom_range(0, 2) == 0);
    endtask

    initial begin
        short_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h0042, 16'h7FFE,
                       16'h0043, 16'hABCD};
        hw_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                    64'h8000_0000_0000_0001, 64'h5555_AAAA_5555_AAAA, 64'h42};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, every command, eviction, reclaim, table full
        issue(CMD_FIND_SH, 16'h0000, '0, 1'b0, 1'b1, 4'd0, '0, 1'b0);
        issue(CMD_UPSERT, 16'h0000, '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_UPSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_UPSERT, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_UPSERT, 16'h1234, '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_FIND_IEEE, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 4'd0, '0, 1'b0);
        issue(CMD_RESOLVE, 16'h0, '0, 1'b0, 1'b0, 4'd0, 32'd1, 1'b0);
        issue(CMD_RESOLVE, 16'h0, '0, 1'b0, 1'b1, 4'd15, 32'hFFFF_FFFF, 1'b0);
        issue(CMD_CLAIM, 16'h0, '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_CLAIM, 16'h0, '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_RELEASE, 16'h0000, '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_RESET, 16'h0, '0, 1'b0, 1'b0, 4'd1, '0, 1'b0);
        issue(CMD_RECLAIM, 16'h0, '0, 1'b0, 1'b0, 4'd1, '0, 1'b1);
        issue(CMD_UPSERT, 16'h1234, 64'h42, 1'b1, 1'b0, 4'd0, '0, 1'b0);
        issue(CMD_FIND_SH, 16'hFFFF, '0, 1'b0, 1'b1, 4'd0, '0, 1'b0);
        issue(CMD_RECLAIM, 16'h0, '0, 1'b0, 1'b0, 4'd1, '0, 1'b0);
        for (int i = 0; i < 17; i++)
            issue(CMD_UPSERT, 16'(16'h100 + i), '0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
        for (int i = 0; i < 16; i++)
            issue(CMD_RECLAIM, 16'h0, '0, 1'b0, 1'b0, 4'(i), '0, 1'b0);
        // random bursts
        for (int n = 0; n < 1200; ) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                random_item();
                n++;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 30));
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("device_slot_table_tb: PASS");
        else
            $display("device_slot_table_tb: FAIL");
        $finish;
    end

    initial begin
        #1000000;
        $display("device_slot_table_tb: FAIL");
        $finish;
    end
endmodule
